/* design/bvsd_pkg.sv */
// shared types and constants for the ber value stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package bvsd_pkg;

  // sizing
  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int MAX_LEN_OCTETS     = 4;
  localparam int OUT_DEPTH          = 4;

  // first subidentifier split points
  localparam int OID_ARC_STEP = 40;
  localparam int OID_ARC_TOP  = 80;

  // identifier bytes that get special handling
  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] TAG_BITSTR    = 8'h03;
  localparam logic [7:0] TAG_OCTETSTR  = 8'h04;
  localparam logic [7:0] TAG_OID       = 8'h06;
  localparam logic [7:0] TAG_COUNTER   = 8'h41;
  localparam logic [7:0] TAG_TIMETICKS = 8'h43;

  // result kinds
  localparam logic [2:0] K_STR  = 3'd0;
  localparam logic [2:0] K_SUB  = 3'd1;
  localparam logic [2:0] K_INT  = 3'd2;
  localparam logic [2:0] K_UINT = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;
  localparam logic [2:0] K_ERR  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXT_TAG   = 3'd1;
  localparam logic [2:0] ST_INDEF     = 3'd2;
  localparam logic [2:0] ST_LONG_LEN  = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;
  localparam logic [2:0] ST_EMPTY_OID = 3'd5;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN1,
    PH_LENX,
    PH_CONTENT
  } phase_t;

  typedef enum logic [2:0] {
    CL_INT,
    CL_UINT,
    CL_STR,
    CL_OID,
    CL_OTHER
  } tag_class_t;

  typedef struct packed {
    logic [7:0]  byte_in;
    logic [15:0] bytes_left;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [31:0] value;
    logic [31:0] obj_length;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // up to two results per byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } res_bundle_t;

endpackage

`default_nettype wire

/* design/bvsd_decode.sv */
// per-byte decode: parse state registers and the combinational step
// depends on bvsd_pkg
`default_nettype none

module bvsd_decode import bvsd_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire in_item_t    item,
  output res_bundle_t      res
);

  phase_t                  phase, phase_next;
  logic [7:0]              tag_held, tag_held_next;
  logic [2:0]              len_left, len_left_next;
  logic [2:0]              header_count, header_count_next;
  logic [31:0]             length_acc, length_acc_next;
  logic [31:0]             content_left, content_left_next;
  logic [VALUE_BITS-1:0]   value_acc, value_acc_next;
  logic                    first_pending, first_pending_next;
  logic [15:0]             space_held, space_held_next;

  logic [7:0]              b;
  tag_class_t              cls;
  logic                    hd_go;
  logic                    overrun;
  logic                    first_byte;
  logic                    fin;
  logic [31:0]             cl_dec;
  logic [VALUE_BITS-1:0]   int_base;
  logic [VALUE_BITS-1:0]   sub_acc;
  logic [VALUE_BITS-1:0]   sub_lo;
  logic [31:0]             sub_hi;

  function automatic tag_class_t class_of(input logic [7:0] t);
    tag_class_t c;
    case (t)
      TAG_INTEGER:                c = CL_INT;
      TAG_COUNTER, TAG_TIMETICKS: c = CL_UINT;
      TAG_BITSTR, TAG_OCTETSTR:   c = CL_STR;
      TAG_OID:                    c = CL_OID;
      default:                    c = CL_OTHER;
    endcase
    return c;
  endfunction

  assign b   = item.byte_in;
  assign cls = class_of(tag_held);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      tag_held      <= '0;
      len_left      <= '0;
      header_count  <= '0;
      length_acc    <= '0;
      content_left  <= '0;
      value_acc     <= '0;
      first_pending <= 1'b1;
      space_held    <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      tag_held      <= tag_held_next;
      len_left      <= len_left_next;
      header_count  <= header_count_next;
      length_acc    <= length_acc_next;
      content_left  <= content_left_next;
      value_acc     <= value_acc_next;
      first_pending <= first_pending_next;
      space_held    <= space_held_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    tag_held_next      = tag_held;
    len_left_next      = len_left;
    header_count_next  = header_count;
    length_acc_next    = length_acc;
    content_left_next  = content_left;
    value_acc_next     = value_acc;
    first_pending_next = first_pending;
    space_held_next    = space_held;
    hd_go              = 1'b0;
    overrun            = 1'b0;
    first_byte         = 1'b0;
    fin                = 1'b0;
    cl_dec             = '0;
    int_base           = '0;
    sub_acc            = '0;
    sub_lo             = '0;
    sub_hi             = '0;

    res.cnt    = 2'd0;
    res.first  = '{kind: K_DONE, tag: tag_held, value: 32'd0, obj_length: 32'd0,
                   status: ST_OK, last: 1'b1};
    res.second = res.first;

    case (phase)
      PH_TAG: begin
        tag_held_next     = b;
        space_held_next   = item.bytes_left;
        header_count_next = 3'd1;
        length_acc_next   = '0;
        res.first.tag     = b;
        if (b[4:0] == 5'h1f) begin
          res.cnt          = 2'd1;
          res.first.kind   = K_ERR;
          res.first.status = ST_EXT_TAG;
          phase_next       = PH_TAG;
        end else begin
          phase_next = PH_LEN1;
        end
      end
      PH_LEN1: begin
        header_count_next = 3'd2;
        if (!b[7]) begin
          length_acc_next = {24'd0, b};
          hd_go           = 1'b1;
        end else if (b[6:0] == 7'd0) begin
          res.cnt          = 2'd1;
          res.first.kind   = K_ERR;
          res.first.status = ST_INDEF;
          phase_next       = PH_TAG;
        end else if (b[6:0] > 7'(MAX_LEN_OCTETS)) begin
          res.cnt          = 2'd1;
          res.first.kind   = K_ERR;
          res.first.status = ST_LONG_LEN;
          phase_next       = PH_TAG;
        end else begin
          len_left_next   = b[2:0];
          length_acc_next = '0;
          phase_next      = PH_LENX;
        end
      end
      PH_LENX: begin
        header_count_next = header_count + 3'd1;
        length_acc_next   = {length_acc[23:0], b};
        len_left_next     = len_left - 3'd1;
        hd_go             = (len_left_next == 3'd0);
      end
      PH_CONTENT: begin
        first_byte        = (content_left == length_acc);
        cl_dec            = content_left - 32'd1;
        content_left_next = cl_dec;
        fin               = (cl_dec == 32'd0);
        if (fin) begin
          phase_next = PH_TAG;
        end
        res.first.obj_length  = length_acc;
        res.second.obj_length = length_acc;
        case (cls)
          CL_INT, CL_UINT: begin
            // first byte seeds the sign fill
            if (first_byte) begin
              int_base = b[7] ? '1 : '0;
            end else begin
              int_base = value_acc;
            end
            value_acc_next = VALUE_BITS'({int_base, b});
            if (fin) begin
              res.cnt         = 2'd1;
              res.first.kind  = (cls == CL_INT) ? K_INT : K_UINT;
              res.first.value = 32'(value_acc_next);
            end
          end
          CL_STR: begin
            res.cnt         = 2'd1;
            res.first.kind  = K_STR;
            res.first.value = {24'd0, b};
            res.first.last  = fin;
          end
          CL_OID: begin
            sub_acc = VALUE_BITS'({value_acc, b[6:0]});
            if (!b[7]) begin
              value_acc_next = '0;
              if (first_pending) begin
                // first subidentifier splits into two arcs
                if (sub_acc < VALUE_BITS'(OID_ARC_STEP)) begin
                  sub_hi = 32'd0;
                  sub_lo = sub_acc;
                end else if (sub_acc < VALUE_BITS'(OID_ARC_TOP)) begin
                  sub_hi = 32'd1;
                  sub_lo = sub_acc - VALUE_BITS'(OID_ARC_STEP);
                end else begin
                  sub_hi = 32'd2;
                  sub_lo = sub_acc - VALUE_BITS'(OID_ARC_TOP);
                end
                res.cnt            = 2'd2;
                res.first.kind     = K_SUB;
                res.first.value    = sub_hi;
                res.first.last     = 1'b0;
                res.second.kind    = K_SUB;
                res.second.value   = 32'(sub_lo);
                res.second.last    = fin;
                first_pending_next = 1'b0;
              end else begin
                res.cnt         = 2'd1;
                res.first.kind  = K_SUB;
                res.first.value = 32'(sub_acc);
                res.first.last  = fin;
              end
            end else begin
              value_acc_next = sub_acc;
              if (fin) begin
                res.cnt = 2'd1;
                if (first_pending) begin
                  res.first.kind   = K_ERR;
                  res.first.status = ST_EMPTY_OID;
                end
              end
            end
          end
          default: begin
            if (fin) begin
              res.cnt = 2'd1;
            end
          end
        endcase
      end
      default: begin
        phase_next = PH_TAG;
      end
    endcase

    // end of header: overrun check and zero-length objects
    if (hd_go) begin
      overrun = ({17'd0, space_held} < ({1'b0, length_acc_next} + 33'(header_count_next)));
      if (overrun) begin
        res.cnt              = 2'd1;
        res.first.kind       = K_ERR;
        res.first.status     = ST_OVERRUN;
        res.first.obj_length = length_acc_next;
        phase_next           = PH_TAG;
      end else if (length_acc_next == 32'd0) begin
        res.cnt    = 2'd1;
        phase_next = PH_TAG;
        case (cls)
          CL_INT:  res.first.kind = K_INT;
          CL_UINT: res.first.kind = K_UINT;
          CL_OID: begin
            res.first.kind   = K_ERR;
            res.first.status = ST_EMPTY_OID;
          end
          default: res.first.kind = K_DONE;
        endcase
      end else begin
        phase_next         = PH_CONTENT;
        content_left_next  = length_acc_next;
        value_acc_next     = '0;
        first_pending_next = 1'b1;
      end
    end
  end

  a_two_only_subid: assert property (@(posedge clk) disable iff (rst)
    res.cnt == 2'd2 |-> (res.first.kind == K_SUB && res.second.kind == K_SUB
                         && !res.first.last))
    else $error("two results from one byte must be the split first subidentifier");

  a_status_err: assert property (@(posedge clk) disable iff (rst)
    (res.cnt != 2'd0 && res.first.status != ST_OK)
      |-> (res.first.kind == K_ERR && res.first.last))
    else $error("nonzero status without a final error result");

  a_content_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CONTENT |-> content_left != 32'd0)
    else $error("content phase with nothing left to read");

  a_lenx_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LENX |-> (len_left != 3'd0 && len_left <= 3'(MAX_LEN_OCTETS)))
    else $error("length octet count out of range");

endmodule

`default_nettype wire

/* design/bvsd_out_queue.sv */
// result queue: shifting register queue, up to two entries in per cycle
// depends on bvsd_pkg
`default_nettype none

module bvsd_out_queue import bvsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_en,
  input  wire res_bundle_t push,
  input  wire logic        pop,
  output out_item_t        head,
  output logic             head_valid,
  output logic             room
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  out_item_t       slot [OUT_DEPTH];
  out_item_t       slot_next [OUT_DEPTH];
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   base;
  logic [1:0]      n_in;
  logic            do_pop;

  assign head       = slot[0];
  assign head_valid = (count != '0);
  assign room       = (count <= CW'(OUT_DEPTH - 2));
  assign do_pop     = pop && head_valid;
  assign n_in       = push_en ? push.cnt : 2'd0;
  assign base       = count - CW'(do_pop);

  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (do_pop && i < OUT_DEPTH - 1) begin
        slot_next[i] = slot[i+1];
      end else begin
        slot_next[i] = slot[i];
      end
      if (n_in != 2'd0 && CW'(i) == base) begin
        slot_next[i] = push.first;
      end
      if (n_in == 2'd2 && CW'(i) == base + CW'(1)) begin
        slot_next[i] = push.second;
      end
    end
    count_next = base + CW'(n_in);
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(OUT_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire

/* design/ber_value_stream_decoder.sv */
// top level of the ber value stream decoder: byte decode plus result queue
// depends on bvsd_pkg, bvsd_decode, bvsd_out_queue
`default_nettype none

// Takes one byte of a BER encoded message per item and decodes value after
// value: identifier byte, definite length (short form or up to four long form
// octets), then content. Each byte is decoded in the cycle it is accepted and
// its results are written to a four-entry result queue, so a result item is
// never offered in the cycle of the byte that causes it. Throughput is one
// byte per cycle: byte_ready stays high while the queue holds at most two
// items, which leaves room for the two results of the byte that closes the
// first subidentifier of an object identifier. With result_ready held high
// the queue never fills and byte_ready never drops. INTEGER, Counter and
// TimeTicks content is sign-extended alike, the latter two under the unsigned
// kind; string bytes come out one per item, object identifiers one arc per
// item with the first subidentifier split in two, and any other tag yields a
// single done item at its last byte. Every error gives one error item with
// last set and the decoder then expects a new identifier byte.

module ber_value_stream_decoder import bvsd_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  output logic           byte_ready,
  input  wire in_item_t  byte_item,
  output logic           result_valid,
  input  wire logic      result_ready,
  output out_item_t      result_item
);

  logic        fire;
  res_bundle_t res;
  logic        room;

  // accept a byte whenever the queue can absorb two results
  assign byte_ready = room;
  assign fire       = byte_valid && byte_ready;

  bvsd_decode #(
    .VALUE_BITS(VALUE_BITS)
  ) u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (byte_item),
    .res  (res)
  );

  // the queue head is the output register
  bvsd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (fire),
    .push       (res),
    .pop        (result_ready),
    .head       (result_item),
    .head_valid (result_valid),
    .room       (room)
  );

endmodule

`default_nettype wire

/* sim/bvsd_checker.sv */
`timescale 1ns / 1ps
// result checker for the ber value stream decoder: predicts the result items
// of every accepted byte and compares them with what the block hands out
// depends on bvsd_pkg for the item types, result kinds and status codes

module bvsd_checker import bvsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      byte_ready,
  input  in_item_t  byte_item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result_item,
  output int        failures,
  output int        pending
);

  phase_t      phase;
  logic [7:0]  cur_tag;
  logic [2:0]  len_octets_left;
  logic [2:0]  header_cnt;
  logic [31:0] len_acc;
  logic [31:0] content_left;
  logic [31:0] value_acc;
  logic        split_pending;
  logic [15:0] space;

  out_item_t predicted_results[$];

  function automatic tag_class_t class_of(logic [7:0] t);
    case (t)
      TAG_INTEGER:                return CL_INT;
      TAG_COUNTER, TAG_TIMETICKS: return CL_UINT;
      TAG_BITSTR, TAG_OCTETSTR:   return CL_STR;
      TAG_OID:                    return CL_OID;
      default:                    return CL_OTHER;
    endcase
  endfunction

  task automatic emit(logic [2:0] kind, logic [31:0] value, logic [31:0] len,
                      logic [2:0] status, logic last);
    out_item_t r;
    r.kind       = kind;
    r.tag        = cur_tag;
    r.value      = value;
    r.obj_length = len;
    r.status     = status;
    r.last       = last;
    predicted_results.push_back(r);
  endtask

  task automatic raise_error(logic [2:0] status, logic [31:0] len);
    phase = PH_TAG;
    emit(K_ERR, '0, len, status, 1'b1);
  endtask

  task automatic close_header();
    tag_class_t c;
    logic [32:0] need;
    c = class_of(cur_tag);
    need = {1'b0, len_acc} + 33'(header_cnt);
    if ({17'd0, space} < need) begin
      raise_error(ST_OVERRUN, len_acc);
    end else if (len_acc == 0) begin
      phase = PH_TAG;
      case (c)
        CL_INT:  emit(K_INT, '0, '0, ST_OK, 1'b1);
        CL_UINT: emit(K_UINT, '0, '0, ST_OK, 1'b1);
        CL_OID:  raise_error(ST_EMPTY_OID, '0);
        default: emit(K_DONE, '0, '0, ST_OK, 1'b1);
      endcase
    end else begin
      phase         = PH_CONTENT;
      content_left  = len_acc;
      value_acc     = '0;
      split_pending = 1'b1;
    end
  endtask

  task automatic take_content(logic [7:0] b);
    tag_class_t c;
    logic first;
    logic fin;
    logic [31:0] hi;
    logic [31:0] lo;
    c = class_of(cur_tag);
    first = (content_left == len_acc);
    content_left = content_left - 32'd1;
    fin = (content_left == 0);
    if (fin) phase = PH_TAG;
    case (c)
      CL_INT, CL_UINT: begin
        if (first) value_acc = b[7] ? '1 : '0;
        value_acc = {value_acc[23:0], b};
        if (fin) emit((c == CL_INT) ? K_INT : K_UINT, value_acc, len_acc, ST_OK, 1'b1);
      end
      CL_STR: emit(K_STR, {24'd0, b}, len_acc, ST_OK, fin);
      CL_OID: begin
        value_acc = {value_acc[24:0], b[6:0]};
        if (!b[7]) begin
          if (split_pending) begin
            // first subidentifier carries two arcs
            if (value_acc < 32'(OID_ARC_STEP)) begin
              hi = 32'd0;
              lo = value_acc;
            end else if (value_acc < 32'(OID_ARC_TOP)) begin
              hi = 32'd1;
              lo = value_acc - 32'(OID_ARC_STEP);
            end else begin
              hi = 32'd2;
              lo = value_acc - 32'(OID_ARC_TOP);
            end
            emit(K_SUB, hi, len_acc, ST_OK, 1'b0);
            emit(K_SUB, lo, len_acc, ST_OK, fin);
            split_pending = 1'b0;
          end else begin
            emit(K_SUB, value_acc, len_acc, ST_OK, fin);
          end
          value_acc = '0;
        end else if (fin) begin
          // object ends inside a subidentifier
          if (split_pending) raise_error(ST_EMPTY_OID, len_acc);
          else emit(K_DONE, '0, len_acc, ST_OK, 1'b1);
        end
      end
      default: if (fin) emit(K_DONE, '0, len_acc, ST_OK, 1'b1);
    endcase
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0] b;
    b = it.byte_in;
    case (phase)
      PH_TAG: begin
        cur_tag    = b;
        space      = it.bytes_left;
        header_cnt = 3'd1;
        len_acc    = '0;
        if (b[4:0] == 5'h1F) raise_error(ST_EXT_TAG, '0);
        else phase = PH_LEN1;
      end
      PH_LEN1: begin
        header_cnt = 3'd2;
        if (!b[7]) begin
          len_acc = {24'd0, b};
          close_header();
        end else if (b[6:0] == 0) begin
          raise_error(ST_INDEF, '0);
        end else if (b[6:0] > MAX_LEN_OCTETS) begin
          raise_error(ST_LONG_LEN, '0);
        end else begin
          len_octets_left = b[2:0];
          len_acc         = '0;
          phase           = PH_LENX;
        end
      end
      PH_LENX: begin
        header_cnt      = header_cnt + 3'd1;
        len_acc         = {len_acc[23:0], b};
        len_octets_left = len_octets_left - 3'd1;
        if (len_octets_left == 0) close_header();
      end
      default: take_content(b);
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      phase           = PH_TAG;
      cur_tag         = '0;
      len_octets_left = '0;
      header_cnt      = '0;
      len_acc         = '0;
      content_left    = '0;
      value_acc       = '0;
      split_pending   = 1'b1;
      space           = '0;
      predicted_results.delete();
    end else begin
      // a result is never caused by the byte taken at the same edge
      if (result_valid && result_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with nothing predicted: kind %0d tag %h value %h",
                 result_item.kind, result_item.tag, result_item.value);
          failures++;
        end else begin
          want = predicted_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(result_item.kind));
          check_field("tag", 32'(want.tag), 32'(result_item.tag));
          check_field("value", want.value, result_item.value);
          check_field("obj_length", want.obj_length, result_item.obj_length);
          check_field("status", 32'(want.status), 32'(result_item.status));
          check_field("last", 32'(want.last), 32'(result_item.last));
        end
      end
      if (byte_valid && byte_ready) decode_byte(byte_item);
    end
    pending = predicted_results.size();
  end

endmodule

/* sim/tb_ber_value_stream_decoder.sv */
`timescale 1ns / 1ps
// testbench top for the ber value stream decoder: clock, reset, byte stimulus,
// result back-pressure and the verdict; depends on bvsd_pkg, bvsd_checker
// and the block itself

module tb_ber_value_stream_decoder;
  import bvsd_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result_item;
  int        failures;
  int        pending;

  // stimulus controls seen by the result side
  bit calm = 1'b0;
  int stall_requests = 0;
  int stalls_served = 0;
  int stall_left = 0;
  int sent = 0;

  // message under construction: bytes and which of them start an object
  logic [7:0] msg_bytes[$];
  bit         msg_head[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ber_value_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  bvsd_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .failures     (failures),
    .pending      (pending)
  );

  // result side: random stalls, none while calm, and one long hold-off
  // per request so the result queue fills and byte_ready drops
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (stall_requests != stalls_served) begin
      stalls_served++;
      stall_left = 80;
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // offer one item, idling now and then; valid stays up between items
  task automatic send_byte(logic [7:0] b, logic [15:0] left);
    while (!calm && $urandom_range(99) < 6) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{byte_in: b, bytes_left: left};
    do @(posedge clk); while (!byte_ready);
    sent++;
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b, bit head);
    msg_bytes.push_back(b);
    msg_head.push_back(head);
  endtask

  // any identifier that is not the extended-tag escape
  function automatic logic [7:0] plain_tag();
    logic [7:0] t;
    t = 8'($urandom);
    if (t[4:0] == 5'h1F) t[4] = 1'b0;
    return t;
  endfunction

  // definite length, short form mostly, long form with optional leading zeros
  task automatic put_len(int n);
    int need;
    int octets;
    if (n < 128 && $urandom_range(3) != 0) begin
      push_byte(8'(n), 1'b0);
    end else begin
      need = (n < 256) ? 1 : (n < 65536) ? 2 : (n < 16777216) ? 3 : 4;
      octets = $urandom_range(need, MAX_LEN_OCTETS);
      push_byte(8'h80 | 8'(octets), 1'b0);
      for (int i = octets - 1; i >= 0; i--) push_byte(8'(n >> (8 * i)), 1'b0);
    end
  endtask

  // a well-formed object with random content
  task automatic add_object();
    logic [7:0] body[$];
    logic [7:0] t;
    logic [7:0] b;
    int pick;
    int n;
    int nb;
    pick = $urandom_range(99);
    if (pick < 20) t = TAG_INTEGER;
    else if (pick < 28) t = TAG_COUNTER;
    else if (pick < 34) t = TAG_TIMETICKS;
    else if (pick < 50) t = TAG_OCTETSTR;
    else if (pick < 56) t = TAG_BITSTR;
    else if (pick < 74) t = TAG_OID;
    else t = plain_tag();
    if (t == TAG_OID) begin
      n = $urandom_range(1, 4);
      for (int s = 0; s < n; s++) begin
        // mostly single-byte subidentifiers, some long enough to wrap 32 bits
        nb = ($urandom_range(9) < 6) ? 1 : $urandom_range(2, 5);
        for (int j = 0; j < nb; j++) begin
          b = 8'($urandom);
          b[7] = (j != nb - 1);
          body.push_back(b);
        end
      end
      // object that ends inside a subidentifier
      if ($urandom_range(99) < 15) body[body.size() - 1][7] = 1'b1;
    end else begin
      if (t == TAG_INTEGER || t == TAG_COUNTER || t == TAG_TIMETICKS)
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      else if ((t == TAG_OCTETSTR || t == TAG_BITSTR) && $urandom_range(99) < 4)
        n = $urandom_range(120, 140);
      else
        n = $urandom_range(0, 10);
      for (int j = 0; j < n; j++) body.push_back(8'($urandom));
    end
    push_byte(t, 1'b1);
    put_len(body.size());
    foreach (body[j]) push_byte(body[j], 1'b0);
  endtask

  // malformed headers, cut-short objects and plain noise
  task automatic add_broken();
    int n;
    case ($urandom_range(5))
      0: push_byte({3'($urandom), 5'h1F}, 1'b1);
      1: begin
        push_byte(plain_tag(), 1'b1);
        push_byte(8'h80, 1'b0);
      end
      2: begin
        push_byte(plain_tag(), 1'b1);
        push_byte(8'h80 | 8'($urandom_range(MAX_LEN_OCTETS + 1, 127)), 1'b0);
      end
      3: begin
        // length far beyond any buffer
        push_byte(plain_tag(), 1'b1);
        push_byte(8'h84, 1'b0);
        push_byte(8'h80 | 8'($urandom), 1'b0);
        for (int j = 0; j < 3; j++) push_byte(8'($urandom), 1'b0);
      end
      4: begin
        n = $urandom_range(3, 8);
        push_byte(plain_tag(), 1'b1);
        push_byte(8'(n), 1'b0);
        for (int j = $urandom_range(0, n - 1); j > 0; j--) push_byte(8'($urandom), 1'b0);
      end
      default: for (int j = $urandom_range(1, 4); j > 0; j--) push_byte(8'($urandom), 1'b0);
    endcase
  endtask

  // send the message; an object start carries the room left in the buffer,
  // sometimes a little short of it or arbitrary, other bytes carry noise
  task automatic flush_message();
    int room;
    int r;
    logic [15:0] left;
    foreach (msg_bytes[i]) begin
      room = msg_bytes.size() - i;
      r = $urandom_range(99);
      if (!msg_head[i] || r < 5) left = 16'($urandom);
      else if (r < 10) left = (room > 3) ? 16'(room - $urandom_range(1, 3)) : 16'd0;
      else left = 16'(room);
      send_byte(msg_bytes[i], left);
    end
    msg_bytes.delete();
    msg_head.delete();
  endtask

  initial begin
    // directed opening: every error status, empty integer, other-tag and oid
    // content, the oid corner cases, long-form length, and both extremes of both fields
    logic [7:0]  opening_bytes[24] = '{
      8'hFF,                          // extended tag escape
      8'h04, 8'h80,                   // indefinite length
      8'h04, 8'h85,                   // too many length octets
      8'h04, 8'h05,                   // object longer than the room left
      8'h02, 8'h00,                   // empty integer
      8'h05, 8'h00,                   // empty other tag
      8'h06, 8'h00,                   // empty oid
      8'h06, 8'h01, 8'h81,            // oid with no complete subidentifier
      8'h06, 8'h02, 8'h2B, 8'h81,     // oid ending inside a subidentifier
      8'h41, 8'h81, 8'h01, 8'hFF      // counter, long-form length, top bit set
    };
    logic [15:0] opening_left[24] = '{
      16'h0000,
      16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF,
      16'h0003, 16'hFFFF,
      16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
    };
    bit stalled;
    bit paused;
    int n_obj;

    stalled = 1'b0;
    paused  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i], opening_left[i]);
    drain();

    // random messages, mostly well-formed objects
    while (sent < 1900) begin
      // a window with no idling on either side
      calm = (sent >= 600 && sent < 900);
      // one long result-side hold-off while bytes keep coming
      if (!stalled && sent >= 1200) begin
        stalled = 1'b1;
        stall_requests++;
      end
      // one sender pause until every result is back
      if (!paused && sent >= 1500) begin
        paused = 1'b1;
        drain();
      end
      n_obj = $urandom_range(1, 4);
      for (int k = 0; k < n_obj; k++) begin
        if ($urandom_range(99) < 85) add_object();
        else add_broken();
      end
      flush_message();
    end
    calm = 1'b0;

    drain();
    // catch any stray result after the last prediction is met
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* ber_value_stream_decoder.f */
design/bvsd_pkg.sv
design/bvsd_decode.sv
design/bvsd_out_queue.sv
design/ber_value_stream_decoder.sv
sim/bvsd_checker.sv
sim/tb_ber_value_stream_decoder.sv
